### sv/url_path_percent_decoder_assert.svh
// assertion macros for the url path decoder
`ifndef URL_PATH_PERCENT_DECODER_ASSERT_SVH
`define URL_PATH_PERCENT_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define UPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upd assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define UPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upd assertion failed");

`endif

### sv/upd_pkg.sv
package upd_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CountW = 12;
  localparam int unsigned SizeW = 13;

  localparam logic [SizeW-1:0] LIMIT_MAX = 13'd4096;
  localparam logic [SizeW-1:0] BUF_SIZE_RESET = 13'd128;

  localparam logic [CharW-1:0] CH_NUL     = 8'h00;
  localparam logic [CharW-1:0] CH_TAB     = 8'h09;
  localparam logic [CharW-1:0] CH_LF      = 8'h0A;
  localparam logic [CharW-1:0] CH_CR      = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CH_PERCENT = 8'h25;
  localparam logic [CharW-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CharW-1:0] CH_DASH    = 8'h2D;
  localparam logic [CharW-1:0] CH_DOT     = 8'h2E;
  localparam logic [CharW-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CharW-1:0] CH_QUEST   = 8'h3F;
  localparam logic [CharW-1:0] CH_UNDER   = 8'h5F;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_DONE   = 2'd1,
    ST_REJECT = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] ch;
    logic             start;
  } item_t;

  typedef struct packed {
    logic [CharW-1:0] byte_val;
    logic             vld;
    status_t          status;
  } result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [CharW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_plain(input logic [CharW-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                      CH_UNDER, CH_DASH, CH_PLUS, CH_SLASH});
  endfunction

endpackage

### sv/upd_in_stage.sv
module upd_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      char_valid,
  input  logic [upd_pkg::CharW-1:0] char_in,
  input  logic                      start_req,
  input  logic                      take,
  output logic                      char_stall,
  output upd_pkg::item_t            item
);
  import upd_pkg::*;

  logic accept;

  assign char_stall = item.valid && !take;
  assign accept = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (accept) begin
      item.valid <= 1'b1;
    end else if (take) begin
      item.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.ch <= char_in;
      item.start <= start_req;
    end
  end

endmodule

### sv/upd_core.sv
`include "url_path_percent_decoder_assert.svh"

module upd_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  upd_pkg::item_t            item,
  input  logic [upd_pkg::SizeW-1:0] buffer_size,
  output upd_pkg::result_t          res
);
  import upd_pkg::*;

  logic              active;
  esc_phase_t        escape_phase;
  logic [3:0]        high_nibble;
  logic [CountW-1:0] bytes_written;
  logic              last_was_dot;

  logic              active_next;
  esc_phase_t        escape_phase_next;
  logic [3:0]        high_nibble_next;
  logic [CountW-1:0] bytes_written_next;
  logic              last_was_dot_next;

  logic [SizeW-1:0]  limit;
  logic [4:0]        hex;
  logic              full;

  assign limit = (buffer_size > LIMIT_MAX) ? LIMIT_MAX : buffer_size;
  assign hex = hex_decode(item.ch);

  always_comb begin
    active_next = active;
    escape_phase_next = escape_phase;
    high_nibble_next = high_nibble;
    bytes_written_next = bytes_written;
    last_was_dot_next = last_was_dot;
    res = '{byte_val: '0, vld: 1'b0, status: ST_BUSY};

    if (item.start) begin
      active_next = 1'b1;
      escape_phase_next = ESC_NONE;
      high_nibble_next = '0;
      bytes_written_next = '0;
      last_was_dot_next = 1'b0;
    end

    full = ({1'b0, bytes_written_next} + 13'd1) >= limit;

    if (!active_next) begin
      res.status = ST_IDLE;
    end else if (escape_phase_next == ESC_HIGH) begin
      if (hex[4]) begin
        high_nibble_next = hex[3:0];
        escape_phase_next = ESC_LOW;
      end else begin
        res.status = ST_REJECT;
      end
    end else if (escape_phase_next == ESC_LOW) begin
      if (hex[4]) begin
        escape_phase_next = ESC_NONE;
        res.byte_val = {high_nibble_next, hex[3:0]};
        res.vld = 1'b1;
        bytes_written_next = bytes_written_next + 12'd1;
      end else begin
        res.status = ST_REJECT;
      end
    end else begin
      case (item.ch)
        CH_NUL, CH_CR, CH_LF, CH_TAB, CH_SPACE, CH_QUEST: begin
          res.vld = 1'b1;
          res.status = ST_DONE;
        end
        CH_DOT: begin
          if (full || last_was_dot_next) begin
            res.status = ST_REJECT;
          end else begin
            last_was_dot_next = 1'b1;
            res.byte_val = item.ch;
            res.vld = 1'b1;
            bytes_written_next = bytes_written_next + 12'd1;
          end
        end
        CH_PERCENT: begin
          if (full) begin
            res.status = ST_REJECT;
          end else begin
            last_was_dot_next = 1'b0;
            escape_phase_next = ESC_HIGH;
          end
        end
        default: begin
          if (full || !is_plain(item.ch)) begin
            res.status = ST_REJECT;
          end else begin
            last_was_dot_next = 1'b0;
            res.byte_val = item.ch;
            res.vld = 1'b1;
            bytes_written_next = bytes_written_next + 12'd1;
          end
        end
      endcase
    end

    // path ends on completion or rejection
    if (res.status == ST_DONE || res.status == ST_REJECT) begin
      active_next = 1'b0;
      escape_phase_next = ESC_NONE;
      high_nibble_next = '0;
      bytes_written_next = '0;
      last_was_dot_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      escape_phase <= ESC_NONE;
      high_nibble <= '0;
      bytes_written <= '0;
      last_was_dot <= 1'b0;
    end else if (step) begin
      active <= active_next;
      escape_phase <= escape_phase_next;
      high_nibble <= high_nibble_next;
      bytes_written <= bytes_written_next;
      last_was_dot <= last_was_dot_next;
    end
  end

  `UPD_ASSERT_NOW(a_idle_clear, !active, escape_phase == ESC_NONE && bytes_written == '0 && !last_was_dot)
  `UPD_ASSERT_NEXT(a_end_deactivates, step && (res.status == ST_DONE || res.status == ST_REJECT), !active)
  `UPD_ASSERT_NOW(a_vld_status, step && res.vld, res.status == ST_BUSY || res.status == ST_DONE)
  `UPD_ASSERT_NEXT(a_high_to_low, step && active && !item.start && escape_phase == ESC_HIGH && res.status == ST_BUSY, escape_phase == ESC_LOW)

endmodule

### sv/url_path_percent_decoder.sv
// URL path percent decoder. Send one raw path character per request on
// char_in, with start_req high on the first character of a path; each
// request yields exactly one result (out_byte, out_valid, status) through
// the input and result registers. A request can be taken every cycle: the
// input register, combinational decode logic against the path state, and
// the result register form the only path, so throughput is one character
// per clock while result_stall is low. Escapes %XX become one byte, '..'
// rejects, NUL/CR/LF/tab/space/'?' complete with a zero terminator, and
// status is 0 in progress, 1 done, 2 rejected, 3 ignored (no path open).
// buffer_size (reset 128, values above 4096 act as 4096) bounds the
// decoded bytes to buffer_size minus one; write it only while idle.
module url_path_percent_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [upd_pkg::SizeW-1:0] cfg_data,
  input  logic                      char_valid,
  output logic                      char_stall,
  input  logic [upd_pkg::CharW-1:0] char_in,
  input  logic                      start_req,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [upd_pkg::CharW-1:0] out_byte,
  output logic                      out_valid,
  output logic [1:0]                status
);
  import upd_pkg::*;

  logic [SizeW-1:0] buffer_size;
  item_t            item;
  result_t          res;
  result_t          result;
  logic             out_ready;
  logic             take;

  assign out_ready = !result_valid || !result_stall;
  assign take = item.valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUF_SIZE_RESET;
    end else if (cfg_we) begin
      buffer_size <= cfg_data;
    end
  end

  upd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_in    (char_in),
    .start_req  (start_req),
    .take       (take),
    .char_stall (char_stall),
    .item       (item)
  );

  upd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (take),
    .item        (item),
    .buffer_size (buffer_size),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

  assign out_byte = result.byte_val;
  assign out_valid = result.vld;
  assign status = result.status;

endmodule

### test/url_path_percent_decoder_tb.sv
`timescale 1ns / 100ps

module url_path_percent_decoder_tb;
  import upd_pkg::*;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             start_bit;
  } char_req_t;

  localparam int PhaseItems = 50;
  localparam int PhaseCount = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [SizeW-1:0] cfg_data = '0;
  logic char_valid = 1'b0;
  logic char_stall;
  logic [CharW-1:0] char_in = '0;
  logic start_req = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [CharW-1:0] out_byte;
  logic out_valid;
  logic [1:0] status;

  // decoder state as predicted
  logic [SizeW-1:0] buf_size = BUF_SIZE_RESET;
  logic path_open = 1'b0;
  esc_phase_t esc_state = ESC_NONE;
  logic [3:0] hi_digit = '0;
  logic [CountW-1:0] byte_count = '0;
  logic prev_dot = 1'b0;

  char_req_t pending_q[$];
  result_t expected_q[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_rx = 1'b0;
  int queued = 0;
  int chars_sent = 0;
  int results_seen = 0;
  int done_seen = 0;
  int reject_seen = 0;
  int mismatches = 0;

  logic [CharW-1:0] end_chars[6] = '{CH_NUL, CH_CR, CH_LF, CH_TAB, CH_SPACE, CH_QUEST};

  url_path_percent_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_in      (char_in),
    .start_req    (start_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .status       (status)
  );

  always #5 clk = ~clk;

  function automatic logic [4:0] hex_of(input logic [CharW-1:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic is_path_char(input logic [CharW-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == CH_UNDER || c == CH_DASH || c == CH_PLUS || c == CH_SLASH;
  endfunction

  function automatic void clear_path();
    path_open = 1'b0;
    esc_state = ESC_NONE;
    hi_digit = '0;
    byte_count = '0;
    prev_dot = 1'b0;
  endfunction

  function automatic result_t decode_char(input logic [CharW-1:0] c, input logic start_bit);
    result_t r;
    logic [4:0] hx;
    int lim;
    logic full;
    r.byte_val = '0;
    r.vld = 1'b0;
    r.status = ST_BUSY;
    if (start_bit) begin
      clear_path();
      path_open = 1'b1;
    end
    if (!path_open) begin
      r.status = ST_IDLE;
      return r;
    end
    hx = hex_of(c);
    lim = (buf_size > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(buf_size);
    full = (int'(byte_count) + 1 >= lim);
    case (esc_state)
      ESC_HIGH: begin
        if (!hx[4]) begin
          clear_path();
          r.status = ST_REJECT;
        end else begin
          hi_digit = hx[3:0];
          esc_state = ESC_LOW;
        end
      end
      ESC_LOW: begin
        if (!hx[4]) begin
          clear_path();
          r.status = ST_REJECT;
        end else begin
          esc_state = ESC_NONE;
          r.byte_val = {hi_digit, hx[3:0]};
          r.vld = 1'b1;
          byte_count = byte_count + 1'b1;
        end
      end
      default: begin
        if (c == CH_NUL || c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_SPACE ||
            c == CH_QUEST) begin
          clear_path();
          r.vld = 1'b1;
          r.status = ST_DONE;
        end else if (c == CH_DOT) begin
          if (full || prev_dot) begin
            clear_path();
            r.status = ST_REJECT;
          end else begin
            prev_dot = 1'b1;
            r.byte_val = c;
            r.vld = 1'b1;
            byte_count = byte_count + 1'b1;
          end
        end else if (c == CH_PERCENT) begin
          if (full) begin
            clear_path();
            r.status = ST_REJECT;
          end else begin
            prev_dot = 1'b0;
            esc_state = ESC_HIGH;
          end
        end else if (full || !is_path_char(c)) begin
          clear_path();
          r.status = ST_REJECT;
        end else begin
          prev_dot = 1'b0;
          r.byte_val = c;
          r.vld = 1'b1;
          byte_count = byte_count + 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // request side
  always @(posedge clk) begin
    char_req_t nxt;
    logic took;
    int tx_gap;
    if (rst) begin
      char_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      took = char_valid && !char_stall;
      if (took) begin
        expected_q.push_back(decode_char(char_in, start_req));
        chars_sent++;
      end
      if (!char_valid || took) begin
        if (tx_gap > 0) begin
          tx_gap--;
          char_valid <= 1'b0;
        end else if (pending_q.size() != 0 && tx_idle_pct != 0 &&
                     $urandom_range(99) < tx_idle_pct) begin
          tx_gap = $urandom_range(18);
          char_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          char_valid <= 1'b1;
          char_in <= nxt.ch;
          start_req <= nxt.start_bit;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    result_t want;
    int rx_gap;
    if (rst) begin
      result_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: byte %h valid %b status %0d",
                     $time, out_byte, out_valid, status);
        end else begin
          want = expected_q.pop_front();
          if (want.status == ST_DONE) done_seen++;
          if (want.status == ST_REJECT) reject_seen++;
          if (out_byte !== want.byte_val || out_valid !== want.vld ||
              status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d want byte %h vld %b st %0d, got %h %b %0d",
                       $time, results_seen, want.byte_val, want.vld, want.status,
                       out_byte, out_valid, status);
          end
        end
      end
      if (hold_rx) begin
        result_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_stall <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        rx_gap = $urandom_range(18);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic push_char(input logic [CharW-1:0] c, input logic start_bit);
    char_req_t q;
    q.ch = c;
    q.start_bit = start_bit;
    pending_q.push_back(q);
    queued++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
  endtask

  function automatic logic [CharW-1:0] any_path_char();
    string s;
    s = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-+/";
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [CharW-1:0] any_hex_char();
    string s;
    s = "0123456789abcdefABCDEF";
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // mostly well-formed paths, some noise and broken escapes
  task automatic add_path();
    int n;
    int pick;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 4)) push_char(8'($urandom), 1'($urandom));
      return;
    end
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_char(any_path_char(), i == 0);
      end else if (pick < 65) begin
        push_char(CH_DOT, i == 0);
      end else if (pick < 87) begin
        push_char(CH_PERCENT, i == 0);
        push_char(any_hex_char(), 1'b0);
        push_char(any_hex_char(), 1'b0);
      end else if (pick < 92) begin
        push_char(8'($urandom), i == 0);
      end else if (pick < 96) begin
        push_char(CH_PERCENT, i == 0);
        push_char(8'($urandom), 1'b0);
        push_char(8'($urandom), 1'b0);
      end else begin
        push_char(CH_DOT, i == 0);
        push_char(CH_DOT, 1'b0);
      end
    end
    if ($urandom_range(9) != 0) push_char(end_chars[$urandom_range(5)], 1'b0);
  endtask

  task automatic set_buffer_size(input logic [SizeW-1:0] sz);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= sz;
    buf_size = sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain(input int limit);
    for (int k = 0; k < limit && (pending_q.size() != 0 || char_valid ||
                                  expected_q.size() != 0); k++)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // long receiver hold-off while requests keep coming
  initial begin
    do @(negedge clk); while (chars_sent < 200);
    hold_rx = 1'b1;
    repeat (300) @(negedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("url_path_percent_decoder: mismatch");
    $finish;
  end

  initial begin
    int size_plan[PhaseCount];
    int tx_plan[4];
    int rx_plan[4];
    int sz;
    int leftover;
    size_plan = '{1, 0, 2, 8191, 3, 4097, -1, 4096, -1, 128};
    tx_plan = '{8, 0, 20, 35};
    rx_plan = '{15, 30, 0, 8};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 10;
    push_char("x", 1'b0);
    push_str("Az9_-+/.%2e.%fF%00?");
    push_str("..");
    push_char("q", 1'b0);
    push_char(8'hC8, 1'b1);
    push_str("% ");
    drain(1_000_000);

    for (int p = 0; p < PhaseCount; p++) begin
      sz = (size_plan[p] < 0) ? $urandom_range(4, 40) : size_plan[p];
      set_buffer_size(SizeW'(sz));
      tx_idle_pct = (p == PhaseCount - 1) ? 0 : tx_plan[p % 4];
      rx_idle_pct = (p == PhaseCount - 1) ? 0 : rx_plan[p % 4];
      queued = 0;
      while (queued < PhaseItems) add_path();
      drain((p == PhaseCount - 1) ? 20_000 : 1_000_000);
    end

    leftover = expected_q.size();
    if (leftover != 0) begin
      mismatches += leftover;
      $display("%0d expected results never arrived", leftover);
    end
    $display("%0d characters over %0d buffer sizes, %0d results checked", chars_sent,
             PhaseCount + 1, results_seen);
    $display("%0d paths completed, %0d rejected", done_seen, reject_seen);
    if (mismatches == 0) begin
      $display("url_path_percent_decoder: match");
    end else begin
      $display("url_path_percent_decoder: mismatch");
    end
    $finish;
  end

endmodule
